@@ sv/fba_pkg.sv @@
package fba_pkg;

    localparam int FRAME_COUNT_DEF = 32768;
    localparam int FRAME_SHIFT = 12;
    localparam logic [31:0] NO_FRAME = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE = 2'd1;
    localparam logic [1:0] MODE_RESERVE = 2'd2;
    localparam logic [1:0] MODE_TEST = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [19:0] frame_number;
        logic [31:0] phys_address;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_address;
        logic        found;
        logic        frame_used;
    } rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } store_ctl_t;

    function automatic logic [4:0] low_zero(input logic [31:0] word);
        logic [31:0] first;
        logic [4:0]  idx;
        first = ~word & (word + 32'd1);
        idx = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (first[i])
            begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ sv/fba_store.sv @@
module fba_store #(
    parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fba_pkg::store_ctl_t       ctl,
    input  logic [((FRAME_COUNT + 31) / 32 > 1 ? $clog2((FRAME_COUNT + 31) / 32) : 1)-1:0]
                                      rd_waddr,
    input  logic [((FRAME_COUNT + 1023) / 1024 > 1 ? $clog2((FRAME_COUNT + 1023) / 1024) : 1)-1:0]
                                      rd_saddr,
    input  logic [((FRAME_COUNT + 31) / 32 > 1 ? $clog2((FRAME_COUNT + 31) / 32) : 1)-1:0]
                                      wr_waddr,
    input  logic [31:0]               wr_wdata,
    input  logic [((FRAME_COUNT + 1023) / 1024 > 1 ? $clog2((FRAME_COUNT + 1023) / 1024) : 1)-1:0]
                                      wr_saddr,
    input  logic [31:0]               wr_sdata,
    output logic [31:0]               rd_wdata,
    output logic [31:0]               rd_sdata,
    output logic                      ready
);

    localparam int WORD_COUNT = (FRAME_COUNT + 31) / 32;
    localparam int SUM_COUNT = (WORD_COUNT + 31) / 32;
    localparam int WA = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
    localparam int SA = SUM_COUNT > 1 ? $clog2(SUM_COUNT) : 1;

    logic [31:0]   word_mem [WORD_COUNT];
    logic [31:0]   sum_mem [SUM_COUNT];
    logic [31:0]   rd_wdata_reg;
    logic [31:0]   rd_sdata_reg;

    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [WA-1:0] clr_cnt_reg;
    logic [WA-1:0] clr_cnt_next;

    logic          word_we;
    logic [WA-1:0] word_addr;
    logic [31:0]   word_data;
    logic          sum_we;
    logic [SA-1:0] sum_addr;
    logic [31:0]   sum_data;

    // After reset every word is swept to all ones, one word per cycle.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg == WA'(WORD_COUNT - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + WA'(1);
            end
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            word_we = 1'b1;
            word_addr = clr_cnt_reg;
            word_data = '1;
            sum_we = {1'b0, clr_cnt_reg} < (WA + 1)'(SUM_COUNT);
            sum_addr = clr_cnt_reg[SA-1:0];
            sum_data = '1;
        end
        else
        begin
            word_we = ctl.wr;
            word_addr = wr_waddr;
            word_data = wr_wdata;
            sum_we = ctl.wr;
            sum_addr = wr_saddr;
            sum_data = wr_sdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= word_data;
        end
        if (ctl.rd)
        begin
            rd_wdata_reg <= word_mem[rd_waddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_addr] <= sum_data;
        end
        if (ctl.rd)
        begin
            rd_sdata_reg <= sum_mem[rd_saddr];
        end
    end

    assign rd_wdata = rd_wdata_reg;
    assign rd_sdata = rd_sdata_reg;
    assign ready = !clr_busy_reg;

endmodule

@@ sv/frame_bitmap_allocator_unit.sv @@
// Free, reserve and test pass from acceptance through the modify state to the done state,
// which holds the result until the output register is free; a frame beyond the bitmap goes
// straight to done. Allocate first scans the summary words, skipping full ones; each summary
// word covers 1024 frames and is read at one word per cycle. With no free frame the result
// is the all-ones address. A new item is accepted only back in idle. After reset the bitmap
// is swept to all ones, and no item is accepted until the sweep is done.
module frame_bitmap_allocator_unit #(
    parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fba_pkg::rsp_t rsp
);

    localparam int WORD_COUNT = (FRAME_COUNT + 31) / 32;
    localparam int SUM_COUNT = (WORD_COUNT + 31) / 32;
    localparam int WA = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
    localparam int SA = SUM_COUNT > 1 ? $clog2(SUM_COUNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_MOD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [1:0]          mode_reg;
    logic [1:0]          mode_next;
    logic [WA-1:0]       waddr_reg;
    logic [WA-1:0]       waddr_next;
    logic [4:0]          bit_reg;
    logic [4:0]          bit_next;
    logic [SA-1:0]       chk_reg;
    logic [SA-1:0]       chk_next;
    fba_pkg::rsp_t       res_reg;
    fba_pkg::rsp_t       res_next;
    fba_pkg::rsp_t       rsp_reg;
    fba_pkg::rsp_t       rsp_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    fba_pkg::store_ctl_t ctl;
    logic [WA-1:0]       rd_waddr;
    logic [SA-1:0]       rd_saddr;
    logic [31:0]         rd_wdata;
    logic [31:0]         rd_sdata;
    logic [SA-1:0]       mod_saddr;
    logic [31:0]         new_word;
    logic [31:0]         new_sum;
    logic                store_ready;

    logic                accept;
    logic [19:0]         req_frame;
    logic                req_in_range;
    logic [WA-1:0]       req_waddr;
    logic [SA+4:0]       req_wide;
    logic                req_alloc;

    logic                sum_full;
    logic                chk_last;
    logic [SA+4:0]       scan_wide;
    logic [WA-1:0]       scan_waddr;

    logic                mod_alloc;
    logic [4:0]          mod_bit;
    logic [31:0]         mod_mask;
    logic [SA+4:0]       mod_wide;
    logic [WA+4:0]       mod_frame;
    logic [31:0]         alloc_addr;
    logic                out_free;

    assign accept = req_valid && !req_stall;
    assign req_alloc = req.mode == fba_pkg::MODE_ALLOC;
    assign req_frame = (req.mode == fba_pkg::MODE_FREE)
                     ? req.phys_address[31:fba_pkg::FRAME_SHIFT] : req.frame_number;
    assign req_in_range = {1'b0, req_frame} < 21'(FRAME_COUNT);
    assign req_waddr = req_frame[WA+4:5];
    assign req_wide = (SA + 5)'(req_waddr);

    assign sum_full = rd_sdata == '1;
    assign chk_last = chk_reg == SA'(SUM_COUNT - 1);
    assign scan_wide = {chk_reg, fba_pkg::low_zero(rd_sdata)};
    assign scan_waddr = scan_wide[WA-1:0];

    assign mod_alloc = mode_reg == fba_pkg::MODE_ALLOC;
    assign mod_bit = mod_alloc ? fba_pkg::low_zero(rd_wdata) : bit_reg;
    assign mod_mask = 32'd1 << mod_bit;
    assign new_word = (mode_reg == fba_pkg::MODE_FREE) ? (rd_wdata & ~mod_mask)
                                                       : (rd_wdata | mod_mask);
    assign mod_wide = (SA + 5)'(waddr_reg);
    assign mod_saddr = mod_wide[SA+4:5];
    assign new_sum = (rd_sdata & ~(32'd1 << mod_wide[4:0]))
                   | ({31'd0, &new_word} << mod_wide[4:0]);
    assign mod_frame = {waddr_reg, mod_bit};
    assign alloc_addr = 32'(mod_frame) << fba_pkg::FRAME_SHIFT;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        ctl.rd = 1'b0;
        ctl.wr = 1'b0;
        rd_waddr = req_waddr;
        rd_saddr = req_alloc ? '0 : req_wide[SA+4:5];
        case (state_reg)
            ST_IDLE:
            begin
                ctl.rd = accept && (req_alloc || req_in_range);
            end
            ST_SCAN:
            begin
                ctl.rd = !(sum_full && chk_last);
                rd_waddr = scan_waddr;
                rd_saddr = sum_full ? chk_reg + SA'(1) : chk_reg;
            end
            ST_MOD:
            begin
                ctl.wr = mode_reg != fba_pkg::MODE_TEST;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        waddr_next = waddr_reg;
        bit_next = bit_reg;
        chk_next = chk_reg;
        res_next = res_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    waddr_next = req_waddr;
                    bit_next = req_frame[4:0];
                    chk_next = '0;
                    res_next = '0;
                    if (req_alloc)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_in_range)
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!sum_full)
                begin
                    waddr_next = scan_waddr;
                    state_next = ST_MOD;
                end
                else if (chk_last)
                begin
                    res_next.alloc_address = fba_pkg::NO_FRAME;
                    state_next = ST_DONE;
                end
                else
                begin
                    chk_next = chk_reg + SA'(1);
                end
            end
            ST_MOD:
            begin
                if (mod_alloc)
                begin
                    res_next.alloc_address = alloc_addr;
                    res_next.found = 1'b1;
                end
                else if (mode_reg == fba_pkg::MODE_TEST)
                begin
                    res_next.frame_used = rd_wdata[bit_reg];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        waddr_reg <= waddr_next;
        bit_reg <= bit_next;
        chk_reg <= chk_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    fba_store #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_waddr (rd_waddr),
        .rd_saddr (rd_saddr),
        .wr_waddr (waddr_reg),
        .wr_wdata (new_word),
        .wr_saddr (mod_saddr),
        .wr_sdata (new_sum),
        .rd_wdata (rd_wdata),
        .rd_sdata (rd_sdata),
        .ready    (store_ready)
    );

    assign req_stall = (state_reg != ST_IDLE) || !store_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

@@ sv/fba_checker.sv @@
module fba_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input fba_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input fba_pkg::rsp_t rsp
);

    // A stalled result item holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // Only one request item is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request item accepted while another is in work");

    // An allocated address is frame aligned; any other result carries the all-ones address or zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.found && rsp.alloc_address[11:0] == 12'd0)
                   || (!rsp.found && rsp.alloc_address == fba_pkg::NO_FRAME)
                   || (!rsp.found && rsp.alloc_address == 32'd0))
        else $error("allocate result is inconsistent");

    // A test result never comes together with an allocate result.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.frame_used |-> !rsp.found && rsp.alloc_address == 32'd0)
        else $error("test result mixed with allocate result");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (.*);
